// ===== rtl/software_breakpoint_table_unit_assert.svh =====
// Assertion macros for the software breakpoint table unit.
// Included by RTL files that check their own logic; no other dependencies.
`ifndef SOFTWARE_BREAKPOINT_TABLE_UNIT_ASSERT_SVH
`define SOFTWARE_BREAKPOINT_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked at clock edges outside reset.
`define SBT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define SBT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SBT_ASSERT(label, prop, msg)
`define SBT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/sbt_pkg.sv =====
// Types and constants for the software breakpoint table unit.
// No dependencies; imported by software_breakpoint_table_unit.
package sbt_pkg;

   localparam int SLOT_COUNT = 10;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOT_COUNT - 1);

   localparam int CSR_INDEX_W = 1;

   localparam logic [31:0] TRAP_WORD_RESET     = 32'h7FE0_0008;
   localparam logic [31:0] WINDOW_OFFSET_RESET = 32'hA000_0000;

   localparam logic [1:0] STATUS_TRAP     = 2'd0;
   localparam logic [1:0] STATUS_RESTORED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NONE     = 2'd3;

   typedef enum logic {
      OP_TOGGLE     = 1'b0,
      OP_REMOVE_ALL = 1'b1
   } sbt_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRAP_WORD     = 1'b0,
      CSR_WINDOW_OFFSET = 1'b1
   } sbt_csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } sbt_state_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] code_address;
      logic [31:0] current_word;
   } sbt_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        write_enable;
      logic [31:0] write_address;
      logic [31:0] write_data;
      logic        last;
   } sbt_rsp_type;

endpackage

// ===== rtl/software_breakpoint_table_unit.sv =====
// Software breakpoint table unit: slot table, scan sequencer and result register.
// Depends on sbt_pkg and software_breakpoint_table_unit_assert.svh.
//
// Usage:
//   req_*  : one transaction per command (toggle a breakpoint or remove all).
//   rsp_*  : memory-write results; each command ends with a result whose last is set.
//   csr_*  : register writes (index 0 trap word, index 1 write window offset),
//            always ready; write only while the unit is idle.
// One comparator walks the slot table, one slot per cycle unless the scan holds
// (see below). A command is taken in the idle state and then scans: a zero
// address ends on the first scan step, a hit on slot k ends at slot k, a miss
// or table full at the last slot. Remove-all emits one restore write per used
// slot as the scan passes it. The result is registered and shows on rsp_* the
// cycle after its scan step, and the unit takes no new command until its scan
// has ended and it is back in the idle state.
// When a result waits and rsp_ready is low, the scan holds at the slot that has a result to emit;
// a new command is still accepted while a finished result waits.
// Reset frees every slot, restores both registers to their defaults and drops
// any pending result.
`include "software_breakpoint_table_unit_assert.svh"

module software_breakpoint_table_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sbt_pkg::sbt_req_type                 req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sbt_pkg::sbt_rsp_type                 rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sbt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                          csr_wdata
);
   import sbt_pkg::*;

   sbt_state_type           state_ff, state_in;
   logic [SLOT_IDX_W-1:0]   idx_ff, idx_in;
   logic                    free_found_ff, free_found_in;
   logic [SLOT_IDX_W-1:0]   free_idx_ff, free_idx_in;

   sbt_op_type              op_ff;
   logic [31:0]             addr_ff;
   logic [31:0]             word_ff;

   logic [31:0]             trap_word_ff;
   logic [31:0]             window_offset_ff;

   logic [SLOT_COUNT-1:0]   slot_valid_ff;
   logic [31:0]             slot_addr_ff [SLOT_COUNT];
   logic [31:0]             slot_word_ff [SLOT_COUNT];

   logic                    rsp_valid_ff, rsp_valid_in;
   sbt_rsp_type             rsp_ff, rsp_in;

   logic                    req_accept;
   logic                    out_free;
   logic                    cur_valid;
   logic [31:0]             cur_addr;
   logic [31:0]             cur_word;
   logic                    at_end;
   logic                    later_used;

   logic                    slot_set;
   logic [SLOT_IDX_W-1:0]   slot_set_idx;
   logic                    slot_clr;

   logic                    emit;
   logic [1:0]              emit_status;
   logic                    emit_we;
   logic [31:0]             emit_addr;
   logic [31:0]             emit_data;
   logic                    emit_last;
   logic [31:0]             emit_wr_addr;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_valid  = slot_valid_ff[idx_ff];
   assign cur_addr   = slot_addr_ff[idx_ff];
   assign cur_word   = slot_word_ff[idx_ff];
   assign at_end     = (idx_ff == LAST_SLOT);
   assign csr_ready  = 1'b1;

   // any used slot beyond the current scan position
   always_comb begin
      later_used = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if ((SLOT_IDX_W'(i) > idx_ff) && slot_valid_ff[i]) begin
            later_used = 1'b1;
         end
      end
   end

   assign emit_wr_addr = emit_addr + window_offset_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      req_ready     = 1'b0;
      slot_set      = 1'b0;
      slot_set_idx  = idx_ff;
      slot_clr      = 1'b0;
      emit          = 1'b0;
      emit_status   = STATUS_NONE;
      emit_we       = 1'b0;
      emit_addr     = addr_ff;
      emit_data     = cur_word;
      emit_last     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_REMOVE_ALL) begin
               if (cur_valid) begin
                  if (out_free) begin
                     emit        = 1'b1;
                     emit_status = STATUS_RESTORED;
                     emit_we     = 1'b1;
                     emit_addr   = cur_addr;
                     emit_data   = cur_word;
                     emit_last   = !later_used;
                     slot_clr    = 1'b1;
                     if (later_used) begin
                        idx_in = idx_ff + SLOT_IDX_W'(1);
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end else if (at_end) begin
                  // table was empty: report nothing done
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + SLOT_IDX_W'(1);
               end
            end else if (addr_ff == '0) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (cur_valid && (cur_addr == addr_ff)) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = STATUS_RESTORED;
                  emit_we     = 1'b1;
                  emit_data   = cur_word;
                  slot_clr    = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               // remember the lowest free slot
               if (!cur_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (at_end) begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (free_found_ff || !cur_valid) begin
                        emit_status  = STATUS_TRAP;
                        emit_we      = 1'b1;
                        emit_data    = trap_word_ff;
                        slot_set     = 1'b1;
                        slot_set_idx = free_found_ff ? free_idx_ff : idx_ff;
                     end else begin
                        emit_status = STATUS_FULL;
                     end
                  end
               end else begin
                  idx_in = idx_ff + SLOT_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = emit_status;
         rsp_in.write_enable  = emit_we;
         rsp_in.write_address = emit_we ? emit_wr_addr : '0;
         rsp_in.write_data    = emit_we ? emit_data : '0;
         rsp_in.last          = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         idx_ff           <= '0;
         free_found_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         slot_valid_ff    <= '0;
         trap_word_ff     <= TRAP_WORD_RESET;
         window_offset_ff <= WINDOW_OFFSET_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (slot_clr) begin
            slot_valid_ff[idx_ff] <= 1'b0;
         end
         if (slot_set) begin
            slot_valid_ff[slot_set_idx] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (sbt_csr_index_type'(csr_index))
               CSR_TRAP_WORD:     trap_word_ff     <= csr_wdata;
               CSR_WINDOW_OFFSET: window_offset_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
      if (req_accept) begin
         op_ff   <= sbt_op_type'(req_payload.operation);
         addr_ff <= req_payload.code_address;
         word_ff <= req_payload.current_word;
      end
      if (slot_set) begin
         slot_addr_ff[slot_set_idx] <= addr_ff;
         slot_word_ff[slot_set_idx] <= word_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SBT_ASSERT(a_accept_starts_scan, req_accept |=> state_ff == ST_SCAN, "accept did not start scan")
   `SBT_ASSERT(a_idx_in_range, state_ff == ST_SCAN |-> idx_ff <= LAST_SLOT, "scan index out of range")
   `SBT_ASSERT(a_no_write_zero, rsp_valid && !rsp_payload.write_enable |-> rsp_payload.write_address == '0 && rsp_payload.write_data == '0, "result without write carries data")
   `SBT_ASSERT(a_write_status, rsp_valid && rsp_payload.write_enable |-> rsp_payload.status == STATUS_TRAP || rsp_payload.status == STATUS_RESTORED, "write with wrong status")
   `SBT_ASSERT(a_emit_needs_room, emit |-> out_free, "result register overwritten")
   `SBT_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid && state_ff == ST_IDLE && slot_valid_ff == '0, "reset did not clear control state")

endmodule
